[hdl/arpc_pkg.sv]
// Package for the ARP cache responder: shared constants, codes and the
// controller/datapath interface structs. No dependencies.
`timescale 1ns / 1ps
package arpc_pkg;

  localparam int TABLE_ENTRIES_DEF = 32;
  localparam int IP_W   = 32;
  localparam int MAC_W  = 48;
  localparam int AGE_W  = 8;
  localparam int CFG_W  = 48;
  localparam int CFGI_W = 3;

  localparam logic [10:0]      MIN_FRAME_LEN = 11'd28;
  localparam logic [15:0]      OP_REQUEST    = 16'd1;
  localparam logic [15:0]      OP_REPLY      = 16'd2;
  localparam logic [IP_W-1:0]  IP_BCAST      = 32'hFFFF_FFFF;
  localparam logic [MAC_W-1:0] MAC_BCAST     = 48'hFFFF_FFFF_FFFF;

  localparam logic [IP_W-1:0]  MASK_RST      = 32'hFFFF_FF00;
  localparam logic [AGE_W-1:0] MAX_AGE_RST   = 8'd120;

  localparam logic [1:0] CMD_TICK     = 2'd0;
  localparam logic [1:0] CMD_FRAME    = 2'd1;
  localparam logic [1:0] CMD_LOOKUP   = 2'd2;
  localparam logic [1:0] CMD_DISCOVER = 2'd3;

  localparam logic [1:0] SEND_NONE    = 2'd0;
  localparam logic [1:0] SEND_REPLY   = 2'd1;
  localparam logic [1:0] SEND_REQUEST = 2'd2;

  localparam logic [CFGI_W-1:0] REG_HOST_IP     = 3'd0;
  localparam logic [CFGI_W-1:0] REG_HOST_MAC    = 3'd1;
  localparam logic [CFGI_W-1:0] REG_SUBNET_MASK = 3'd2;
  localparam logic [CFGI_W-1:0] REG_ROUTER_IP   = 3'd3;
  localparam logic [CFGI_W-1:0] REG_MAX_AGE     = 3'd4;

  typedef struct packed {
    logic start;
    logic scan;
    logic write;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_done;
  } dp_status_t;

endpackage

[hdl/arp_cache_responder_unit.sv]
// ARP cache responder, top level. Each request is handled by a sequential
// table RAM scan, one entry per cycle, then a table write and a result load.
// A new request is taken only while the controller is idle; the
// result register lets a new request start while the last result waits.
// Reset (rst, synchronous): table emptied, time counter and config restored.
`timescale 1ns / 1ps
module arp_cache_responder_unit import arpc_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CFGI_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        command,
  input  logic [10:0]       frame_len,
  input  logic [15:0]       arp_opcode,
  input  logic [IP_W-1:0]   sender_ip,
  input  logic [MAC_W-1:0]  sender_mac,
  input  logic [IP_W-1:0]   target_ip,
  input  logic [IP_W-1:0]   lookup_ip,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              status,
  output logic              hit,
  output logic [MAC_W-1:0]  found_mac,
  output logic [1:0]        send_kind,
  output logic [MAC_W-1:0]  send_dest_mac,
  output logic [MAC_W-1:0]  send_target_mac,
  output logic [IP_W-1:0]   send_target_ip
);

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  arpc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  arpc_dp #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .command         (command),
    .frame_len       (frame_len),
    .arp_opcode      (arp_opcode),
    .sender_ip       (sender_ip),
    .sender_mac      (sender_mac),
    .target_ip       (target_ip),
    .lookup_ip       (lookup_ip),
    .status          (status),
    .hit             (hit),
    .found_mac       (found_mac),
    .send_kind       (send_kind),
    .send_dest_mac   (send_dest_mac),
    .send_target_mac (send_target_mac),
    .send_target_ip  (send_target_ip)
  );

endmodule

[hdl/arpc_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module arpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/arpc_ctrl.sv]
// Controller state machine for the ARP cache responder.
// Depends on arpc_pkg.
`timescale 1ns / 1ps
module arpc_ctrl import arpc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t sts,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_WRITE = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;

  always_comb begin
    state_next     = state;
    cmd            = '0;
    out_valid_next = out_valid && out_stall;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) state_next = ST_WRITE;
      end
      ST_WRITE: begin
        cmd.write  = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assign in_stall = (state != ST_IDLE);

endmodule

[hdl/arpc_dp.sv]
// Datapath for the ARP cache responder: config registers, table RAM, valid
// bits, sequential table scan and result register. Depends on arpc_pkg, arpc_ram.
`timescale 1ns / 1ps
module arpc_dp import arpc_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  ctrl_cmd_t         cmd,
  output dp_status_t        sts,
  input  logic              cfg_we,
  input  logic [CFGI_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic [1:0]        command,
  input  logic [10:0]       frame_len,
  input  logic [15:0]       arp_opcode,
  input  logic [IP_W-1:0]   sender_ip,
  input  logic [MAC_W-1:0]  sender_mac,
  input  logic [IP_W-1:0]   target_ip,
  input  logic [IP_W-1:0]   lookup_ip,
  output logic              status,
  output logic              hit,
  output logic [MAC_W-1:0]  found_mac,
  output logic [1:0]        send_kind,
  output logic [MAC_W-1:0]  send_dest_mac,
  output logic [MAC_W-1:0]  send_target_mac,
  output logic [IP_W-1:0]   send_target_ip
);

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int RW = IP_W + MAC_W + AGE_W;
  localparam logic [IW:0] N_ENT = (IW+1)'(TABLE_ENTRIES);

  logic [IP_W-1:0]  host_ip, subnet_mask, router_ip;
  logic [MAC_W-1:0] host_mac;
  logic [AGE_W-1:0] max_age, tick_count;

  logic [1:0]       r_cmd;
  logic [10:0]      r_len;
  logic [15:0]      r_op;
  logic [IP_W-1:0]  r_tip, r_lip, r_hop, key;
  logic [MAC_W-1:0] r_smac;

  logic [TABLE_ENTRIES-1:0] valid;
  logic [IW:0]      cnt;
  logic             pend;
  logic [IW-1:0]    rd_idx;
  logic             found, free_found, have_old;
  logic [IW-1:0]    found_idx, free_idx, old_idx;
  logic [AGE_W-1:0] old_age;
  logic [MAC_W-1:0] match_mac;

  logic [RW-1:0]    rdata, wdata;
  logic [IW-1:0]    waddr;
  logic             we;
  logic [IP_W-1:0]  e_ip;
  logic [MAC_W-1:0] e_mac;
  logic [AGE_W-1:0] e_stamp, e_age;
  logic             e_valid, e_match;
  logic [IP_W-1:0]  hop;
  logic             do_store, is_bcast, lk_hit;

  assign hop = ((lookup_ip & subnet_mask) != (host_ip & subnet_mask)) ? router_ip : lookup_ip;

  assign {e_ip, e_mac, e_stamp} = rdata;
  assign e_age   = tick_count - e_stamp;
  assign e_valid = valid[rd_idx];
  assign e_match = e_valid && (e_ip == key);

  assign do_store = (r_cmd == CMD_FRAME) && (r_len >= MIN_FRAME_LEN) && (r_tip == host_ip)
                    && ((r_op == OP_REQUEST) || (r_op == OP_REPLY));
  assign is_bcast = (r_lip == IP_BCAST);
  assign lk_hit   = is_bcast || found;

  assign waddr = found ? found_idx : (free_found ? free_idx : old_idx);
  assign wdata = {key, r_smac, tick_count};
  assign we    = cmd.write && do_store;

  assign sts.scan_done = (cnt == N_ENT) && !pend;

  arpc_ram #(.WIDTH(RW), .DEPTH(TABLE_ENTRIES)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (cnt[IW-1:0]),
    .rdata (rdata)
  );

  // config and time
  always_ff @(posedge clk) begin
    if (rst) begin
      host_ip     <= '0;
      host_mac    <= '0;
      subnet_mask <= MASK_RST;
      router_ip   <= '0;
      max_age     <= MAX_AGE_RST;
      tick_count  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_HOST_IP:     host_ip     <= cfg_data[IP_W-1:0];
          REG_HOST_MAC:    host_mac    <= cfg_data;
          REG_SUBNET_MASK: subnet_mask <= cfg_data[IP_W-1:0];
          REG_ROUTER_IP:   router_ip   <= cfg_data[IP_W-1:0];
          REG_MAX_AGE:     max_age     <= cfg_data[AGE_W-1:0];
          default: ;
        endcase
      end
      if (cmd.start && command == CMD_TICK) tick_count <= tick_count + 1'b1;
    end
  end

  // request latch and scan
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      r_cmd      <= command;
      r_len      <= frame_len;
      r_op       <= arp_opcode;
      r_tip      <= target_ip;
      r_lip      <= lookup_ip;
      r_hop      <= hop;
      r_smac     <= sender_mac;
      key        <= (command == CMD_FRAME) ? sender_ip : hop;
      cnt        <= '0;
      pend       <= 1'b0;
      found      <= 1'b0;
      free_found <= 1'b0;
      have_old   <= 1'b0;
    end else if (cmd.scan) begin
      if (cnt != N_ENT) begin
        rd_idx <= cnt[IW-1:0];
        cnt    <= cnt + 1'b1;
        pend   <= 1'b1;
      end else begin
        pend <= 1'b0;
      end
      if (pend) begin
        if (e_match && !found) begin
          found     <= 1'b1;
          found_idx <= rd_idx;
          match_mac <= e_mac;
        end
        if (!e_valid && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= rd_idx;
        end
        if (e_valid && (!have_old || e_age > old_age)) begin
          have_old <= 1'b1;
          old_age  <= e_age;
          old_idx  <= rd_idx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (cmd.scan && pend && r_cmd == CMD_TICK && e_valid && e_age >= max_age)
        valid[rd_idx] <= 1'b0;
      if (we) valid[waddr] <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status          <= (r_cmd == CMD_FRAME) && (r_len < MIN_FRAME_LEN);
      hit             <= 1'b0;
      found_mac       <= '0;
      send_kind       <= SEND_NONE;
      send_dest_mac   <= '0;
      send_target_mac <= '0;
      send_target_ip  <= '0;
      case (r_cmd) inside
        CMD_FRAME: begin
          if (do_store && r_op == OP_REQUEST) begin
            send_kind       <= SEND_REPLY;
            send_dest_mac   <= r_smac;
            send_target_mac <= r_smac;
            send_target_ip  <= key;
          end
        end
        CMD_LOOKUP, CMD_DISCOVER: begin
          if (lk_hit) begin
            hit       <= 1'b1;
            found_mac <= is_bcast ? MAC_BCAST : match_mac;
          end else if (r_cmd == CMD_DISCOVER) begin
            send_kind      <= SEND_REQUEST;
            send_dest_mac  <= MAC_BCAST;
            send_target_ip <= r_hop;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
